[rtl/ncxy_pkg.sv]
// shared widths, codes, reset values and the scan tag type of the nearest centroid unit
package ncxy_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int DIST_W  = 49;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = DIST_W;

	// table size default
	localparam int MAX_CENTROIDS_DEF = 64;

	// operation codes of the func field
	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	// configuration register indexes
	localparam logic REG_COUNT     = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	// configuration reset values (threshold is 1000 m^2 in Q.20)
	localparam logic [COUNT_W-1:0] RESET_COUNT     = 7'd1;
	localparam logic [DIST_W-1:0]  RESET_THRESHOLD = 49'd1048576000;

	// tag that follows one table read down the distance pipeline
	typedef struct packed {
		logic               vld;
		logic [COUNT_W-1:0] idx;
	} tag_t;

endpackage

[rtl/ncxy_table.sv]
// centroid coordinate memory: one write port, one registered read port
module ncxy_table #(
	parameter int MAX_CENTROIDS = ncxy_pkg::MAX_CENTROIDS_DEF,
	parameter int AW            = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [AW-1:0]                       wr_addr,
	input  logic signed [ncxy_pkg::COORD_W-1:0] wr_x,
	input  logic signed [ncxy_pkg::COORD_W-1:0] wr_y,
	input  logic [AW-1:0]                       rd_addr,
	output logic signed [ncxy_pkg::COORD_W-1:0] rd_x_s1,
	output logic signed [ncxy_pkg::COORD_W-1:0] rd_y_s1
);

	logic signed [ncxy_pkg::COORD_W-1:0] mem_x [MAX_CENTROIDS];
	logic signed [ncxy_pkg::COORD_W-1:0] mem_y [MAX_CENTROIDS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_x_s1 <= mem_x[rd_addr];
		rd_y_s1 <= mem_y[rd_addr];
	end

endmodule

[rtl/ncxy_dist.sv]
// squared xy distance pipeline: difference stage, square stage, then sum
module ncxy_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [ncxy_pkg::COORD_W-1:0] x_s1,
	input  logic signed [ncxy_pkg::COORD_W-1:0] y_s1,
	input  logic signed [ncxy_pkg::COORD_W-1:0] px,
	input  logic signed [ncxy_pkg::COORD_W-1:0] py,
	input  ncxy_pkg::tag_t                      tag_s1,
	output ncxy_pkg::tag_t                      tag_s3,
	output logic [ncxy_pkg::DIST_W-1:0]         dist_s3,
	output logic                                busy
);

	ncxy_pkg::tag_t                     tag_s2;
	logic signed [ncxy_pkg::DIFF_W-1:0] dx_s2;
	logic signed [ncxy_pkg::DIFF_W-1:0] dy_s2;
	logic signed [2*ncxy_pkg::DIFF_W-1:0] prod_x;
	logic signed [2*ncxy_pkg::DIFF_W-1:0] prod_y;
	logic [ncxy_pkg::SQ_W-1:0]          sqx_s3;
	logic [ncxy_pkg::SQ_W-1:0]          sqy_s3;

	// tag valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// exact 25 bit differences
	always_ff @(posedge clk) begin
		dx_s2 <= {x_s1[ncxy_pkg::COORD_W-1], x_s1} - {px[ncxy_pkg::COORD_W-1], px};
		dy_s2 <= {y_s1[ncxy_pkg::COORD_W-1], y_s1} - {py[ncxy_pkg::COORD_W-1], py};
	end

	// squares, magnitude below 2^48
	always_comb begin
		prod_x = dx_s2 * dx_s2;
		prod_y = dy_s2 * dy_s2;
	end

	always_ff @(posedge clk) begin
		sqx_s3 <= prod_x[ncxy_pkg::SQ_W-1:0];
		sqy_s3 <= prod_y[ncxy_pkg::SQ_W-1:0];
	end

	// sum fits 49 bits without overflow
	assign dist_s3 = ncxy_pkg::DIST_W'(sqx_s3) + ncxy_pkg::DIST_W'(sqy_s3);

	assign busy = tag_s2.vld || tag_s3.vld;

endmodule

[rtl/nearest_centroid_xy_assign_unit.sv]
// top level of the nearest centroid unit: table, scan control, running minimum
// a classify word scans N = min(centroids_in_use, MAX_CENTROIDS) slots, one memory read per cycle;
// it passes a start state, N reads on the single table port, the drain of the distance pipeline
// and the load of the output word; input stalls from accept until that load, and a stalled
// output word holds drain
// reset loads the configuration defaults and clears control; the table is undefined until loaded
module nearest_centroid_xy_assign_unit #(
	parameter int MAX_CENTROIDS = ncxy_pkg::MAX_CENTROIDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [ncxy_pkg::CFG_W-1:0]          cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [ncxy_pkg::SLOT_W-1:0]         slot,
	input  logic signed [ncxy_pkg::COORD_W-1:0] coord_x,
	input  logic signed [ncxy_pkg::COORD_W-1:0] coord_y,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ncxy_pkg::SLOT_W-1:0]         nearest_slot,
	output logic [ncxy_pkg::DIST_W-1:0]         nearest_distance,
	output logic                                hit
);

	localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t                              state_q;
	logic [ncxy_pkg::COUNT_W-1:0]        cfg_count_q;
	logic [ncxy_pkg::DIST_W-1:0]         thr_q;
	logic [ncxy_pkg::COUNT_W-1:0]        count_sat;
	logic [ncxy_pkg::COUNT_W-1:0]        count_q;
	logic [ncxy_pkg::COUNT_W-1:0]        scan_q;
	logic                                scan_last;
	logic signed [ncxy_pkg::COORD_W-1:0] px_q;
	logic signed [ncxy_pkg::COORD_W-1:0] py_q;
	logic [ncxy_pkg::DIST_W-1:0]         best_q;
	logic [ncxy_pkg::SLOT_W-1:0]         best_slot_q;
	logic                                hit_q;
	logic                                out_valid_q;
	logic [ncxy_pkg::SLOT_W-1:0]         out_slot_q;
	logic [ncxy_pkg::DIST_W-1:0]         out_dist_q;
	logic                                out_hit_q;
	logic                                in_take;
	logic                                load_en;
	logic                                out_free;
	logic                                out_load;
	logic                                pipe_busy;
	logic                                dist_busy;
	ncxy_pkg::tag_t                      tag_s1;
	ncxy_pkg::tag_t                      tag_s3;
	logic [ncxy_pkg::DIST_W-1:0]         dist_s3;
	logic signed [ncxy_pkg::COORD_W-1:0] rd_x_s1;
	logic signed [ncxy_pkg::COORD_W-1:0] rd_y_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= ncxy_pkg::RESET_COUNT;
			thr_q       <= ncxy_pkg::RESET_THRESHOLD;
		end else if (cfg_write) begin
			case (cfg_index)
				ncxy_pkg::REG_COUNT:     cfg_count_q <= cfg_data[ncxy_pkg::COUNT_W-1:0];
				ncxy_pkg::REG_THRESHOLD: thr_q       <= cfg_data;
				default:                 thr_q       <= thr_q;
			endcase
		end
	end

	// handshake and load decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign load_en   = in_take && (func == ncxy_pkg::FUNC_LOAD) &&
	                   (32'(slot) < MAX_CENTROIDS);
	assign count_sat = (32'(cfg_count_q) > MAX_CENTROIDS) ?
	                   ncxy_pkg::COUNT_W'(MAX_CENTROIDS) : cfg_count_q;
	assign scan_last = (scan_q + 1'b1 == count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign pipe_busy = tag_s1.vld || dist_busy;
	assign out_load  = (state_q == ST_DRAIN) && !pipe_busy && out_free;

	// centroid memory
	ncxy_table #(
		.MAX_CENTROIDS (MAX_CENTROIDS),
		.AW            (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (AW'(slot)),
		.wr_x    (coord_x),
		.wr_y    (coord_y),
		.rd_addr (AW'(scan_q)),
		.rd_x_s1 (rd_x_s1),
		.rd_y_s1 (rd_y_s1)
	);

	// tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= (state_q == ST_SCAN);
			tag_s1.idx <= scan_q;
		end
	end

	// distance pipeline
	ncxy_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_s1    (rd_x_s1),
		.y_s1    (rd_y_s1),
		.px      (px_q),
		.py      (py_q),
		.tag_s1  (tag_s1),
		.tag_s3  (tag_s3),
		.dist_s3 (dist_s3),
		.busy    (dist_busy)
	);

	// scan sequencer, running minimum and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			px_q        <= '0;
			py_q        <= '0;
			best_q      <= '0;
			best_slot_q <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_dist_q  <= '0;
			out_hit_q   <= 1'b0;
		end else begin
			// output word register
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_slot_q  <= best_slot_q;
				out_dist_q  <= best_q;
				out_hit_q   <= hit_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// strict less-than keeps the earlier slot on ties
			if (tag_s3.vld && (dist_s3 < best_q)) begin
				best_q      <= dist_s3;
				best_slot_q <= tag_s3.idx[ncxy_pkg::SLOT_W-1:0];
				hit_q       <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take && (func == ncxy_pkg::FUNC_CLASSIFY)) begin
						px_q        <= coord_x;
						py_q        <= coord_y;
						best_q      <= thr_q;
						best_slot_q <= '0;
						hit_q       <= 1'b0;
						scan_q      <= '0;
						count_q     <= count_sat;
						state_q     <= (count_sat == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign nearest_slot     = out_slot_q;
	assign nearest_distance = out_dist_q;
	assign hit              = out_hit_q;

`ifndef SYNTHESIS
	// a miss reports slot zero
	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_hit_q |-> out_slot_q == '0)
		else $error("miss word carries a nonzero slot");

	// a hit lies strictly under the threshold
	a_hit_below_thr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> out_dist_q < thr_q)
		else $error("hit word not below threshold");

	// nothing in flight while idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pipe_busy && !tag_s3.vld)
		else $error("distance pipeline busy while idle");

	// scan address stays inside the searched range
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q < count_q)
		else $error("scan index past slot count");
`endif

endmodule
